// ----- hw/rtl/wps_pkg.sv -----
// Shared types, constants and table functions of the weight prefetch scheduler.
// Used by weight_prefetch_scheduler_unit, wps_sched and wps_modred; has no dependencies of its own.
package wps_pkg;

    // Layer table and buffer limits
    localparam int TABLE_ENTRIES = 7;
    localparam int TABLE_ROWS    = 7;
    localparam int BUFFER_BYTES  = 8192;

    // Field widths
    localparam int ADDR_W   = 24;
    localparam int LEN_W    = 25;
    localparam int SUSP_W   = 8;
    localparam int ROW_W    = 10;
    localparam int OFFS_W   = 13;
    localparam int BYTES_W  = 14;
    localparam int FRAMES_W = 9;
    localparam int LOADF_W  = 7;
    localparam int FLEN_W   = 9;
    localparam int ENTRY_W  = 3;
    localparam int PROD_W   = 2 * ROW_W;
    localparam int CFG_W    = 25;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSPEND_COUNT = 2'd2;

    // Item kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_ROW   = 1'b1;

    typedef struct packed {
        logic [FRAMES_W-1:0] all_frames;
        logic [FLEN_W-1:0]   frame_bytes;
        logic [LOADF_W-1:0]  load_frames;
    } layer_row_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [LEN_W-1:0]  region_length;
        logic [SUSP_W-1:0] suspend_count;
    } cfg_t;

    typedef struct packed {
        logic                read_buffer;
        logic [OFFS_W-1:0]   read_offset;
        logic                load_issue;
        logic                load_buffer;
        logic [ADDR_W-1:0]   load_address;
        logic [BYTES_W-1:0]  load_length;
    } res_t;

    // Layer table; an entry number past the last row wraps onto row 0
    function automatic layer_row_t layer_row(input logic [ENTRY_W-1:0] e);
        layer_row_t r;
        case (e)
            3'd0:    r = '{9'd128, 9'd120, 7'd68};
            3'd1:    r = '{9'd128, 9'd256, 7'd32};
            3'd2:    r = '{9'd128, 9'd256, 7'd32};
            3'd3:    r = '{9'd128, 9'd256, 7'd32};
            3'd4:    r = '{9'd128, 9'd256, 7'd32};
            3'd5:    r = '{9'd128, 9'd128, 7'd64};
            3'd6:    r = '{9'd488, 9'd128, 7'd64};
            default: r = '{9'd128, 9'd120, 7'd68};
        endcase
        return r;
    endfunction

    // Limit a byte count to the buffer size
    function automatic logic [BYTES_W-1:0] bound_bytes(input logic [15:0] n);
        logic [16:0] lim;
        lim = 17'(BUFFER_BYTES);
        return ({1'b0, n} > lim) ? BYTES_W'(lim) : BYTES_W'(n);
    endfunction

    // Full chunk size of one table row
    function automatic logic [BYTES_W-1:0] chunk_of(input layer_row_t r);
        return bound_bytes(16'(r.frame_bytes) * 16'(r.load_frames));
    endfunction

    localparam logic [BYTES_W-1:0] START_BYTES = chunk_of(layer_row(3'd0));

endpackage

// ----- hw/rtl/weight_prefetch_scheduler_unit.sv -----
// Weight prefetch scheduler top level: stream ports, configuration registers,
// output register. Depends on wps_pkg and instantiates wps_sched.
//
// Usage:
//   Requests enter on s_tvalid/s_tready with s_tuser = action (0 start, 1 row)
//   and s_tdata = row_index, row_length. Each start request and each row
//   request taken while suspend_count is zero gives one result on
//   m_tvalid/m_tready; a row request while suspended is dropped.
//   The block works on one request at a time. A row request runs a radix-4
//   serial remainder of row_index * row_length by the chunk size in 10 digit
//   steps; when it flips the buffers and issues a flash load it runs three
//   more steps: frame select, length, address.
//   The next request is taken as soon as the result moves to the output
//   register, even while the receiver has not taken it yet; a stalled
//   receiver holds m_tdata and m_tuser and blocks only the following result.
//   Reset (rst_n low, asynchronous) clears the layer entry, frame count,
//   buffer select and load address, sets the chunk size to the first table
//   chunk and restores the configuration registers to their defaults.
//   Write configuration registers only while no request is in flight.
module weight_prefetch_scheduler_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // row_index[9:0], row_length[19:10]
    input  logic [0:0]                      s_tuser,   // action[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [55:0]                     m_tdata,   // read_buffer[0], read_offset[13:1],
                                                       // load_buffer[14], load_address[38:15],
                                                       // load_length[52:39]
    output logic [0:0]                      m_tuser,   // load_issue[0]
    input  logic                            cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wps_pkg::CFG_W-1:0]       cfg_data
);
    import wps_pkg::*;

    cfg_t   cfg_reg;
    res_t   res;
    logic   res_valid;
    logic   res_take;
    logic   in_accept;
    logic   m_tvalid_reg;
    res_t   out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_base   <= '0;
            cfg_reg.region_length <= 25'h1000000;
            cfg_reg.suspend_count <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REGION_BASE:   cfg_reg.region_base   <= cfg_data[ADDR_W-1:0];
                CFG_REGION_LENGTH: cfg_reg.region_length <= cfg_data[LEN_W-1:0];
                CFG_SUSPEND_COUNT: cfg_reg.suspend_count <= cfg_data[SUSP_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_accept = s_tvalid && s_tready;

    wps_sched u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .action     (s_tuser[0]),
        .row_index  (s_tdata[ROW_W-1:0]),
        .row_length (s_tdata[2*ROW_W-1:ROW_W]),
        .cfg        (cfg_reg),
        .in_ready   (s_tready),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    // Output register: load when empty or being drained
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_take)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            out_reg <= res;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = out_reg.load_issue;
    assign m_tdata    = {3'b000, out_reg.load_length, out_reg.load_address,
                         out_reg.load_buffer, out_reg.read_offset, out_reg.read_buffer};

endmodule

// ----- hw/rtl/wps_modred.sv -----
// Radix-4 digit-serial remainder unit: (product mod divisor), two bits a cycle.
// Depends on wps_pkg for widths.
module wps_modred (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wps_pkg::PROD_W-1:0]   product,
    input  logic [wps_pkg::BYTES_W-1:0]  divisor,
    output logic                         done,
    output logic [wps_pkg::BYTES_W-1:0]  remainder
);
    import wps_pkg::*;

    localparam int DIGITS = PROD_W / 2;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int T_W    = BYTES_W + 2;

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [BYTES_W-1:0]   div_reg;
    logic [BYTES_W-1:0]   rem_reg;
    logic [BYTES_W-1:0]   rem_next;
    logic [T_W-1:0]       t_val;
    logic [T_W-1:0]       d1;
    logic [T_W-1:0]       d2;
    logic [T_W-1:0]       d3;

    // Shift in the next digit and subtract the largest fitting multiple
    always_comb
    begin
        t_val = {rem_reg, prod_reg[PROD_W-1 -: 2]};
        d1    = T_W'(div_reg);
        d2    = {d1[T_W-2:0], 1'b0};
        d3    = d1 + d2;
        if (div_reg == '0)
            rem_next = '0;
        else if (t_val >= d3)
            rem_next = BYTES_W'(t_val - d3);
        else if (t_val >= d2)
            rem_next = BYTES_W'(t_val - d2);
        else if (t_val >= d1)
            rem_next = BYTES_W'(t_val - d1);
        else
            rem_next = BYTES_W'(t_val);
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= product;
            div_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            prod_reg <= {prod_reg[PROD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/wps_sched.sv -----
// Scheduler sequencer: holds buffer, layer and address state and builds each result.
// Depends on wps_pkg and instantiates wps_modred.
module wps_sched (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_accept,
    input  logic                        action,
    input  logic [wps_pkg::ROW_W-1:0]   row_index,
    input  logic [wps_pkg::ROW_W-1:0]   row_length,
    input  wps_pkg::cfg_t               cfg,
    output logic                        in_ready,
    output logic                        res_valid,
    output wps_pkg::res_t               res,
    input  logic                        res_take
);
    import wps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_LOAD1 = 7'b0001000,
        S_LOAD2 = 7'b0010000,
        S_LOAD3 = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   action_reg;
    logic [ROW_W-1:0]       row_index_reg;
    logic [ROW_W-1:0]       row_length_reg;
    logic [ENTRY_W-1:0]     entry_reg, entry_next;
    logic [FRAMES_W-1:0]    frames_left_reg, frames_left_next;
    logic                   active_reg, active_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [BYTES_W-1:0]     chunk_reg, chunk_next;
    logic [LOADF_W-1:0]     frames_reg, frames_next;
    logic [FLEN_W-1:0]      flen_reg, flen_next;
    logic [BYTES_W-1:0]     len_reg, len_next;
    logic [LEN_W:0]         end_reg, end_next;
    res_t                   res_reg, res_next;

    logic                   mod_start;
    logic                   mod_done;
    logic [BYTES_W-1:0]     mod_rem;
    logic [PROD_W-1:0]      product;
    logic [ENTRY_W:0]       entry_inc;
    layer_row_t             row_sel;
    logic [ADDR_W:0]        adv;

    wps_modred u_modred (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .product   (product),
        .divisor   (chunk_next),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign product = PROD_W'(row_index_reg) * PROD_W'(row_length_reg);

    // Next-state and datapath logic
    always_comb
    begin
        state_next       = state_reg;
        entry_next       = entry_reg;
        frames_left_next = frames_left_reg;
        active_next      = active_reg;
        addr_next        = addr_reg;
        chunk_next       = chunk_reg;
        frames_next      = frames_reg;
        flen_next        = flen_reg;
        len_next         = len_reg;
        end_next         = end_reg;
        res_next         = res_reg;
        mod_start        = 1'b0;
        entry_inc        = {1'b0, entry_reg} + 1'b1;
        row_sel          = layer_row(entry_reg);
        adv              = {1'b0, addr_reg} + (ADDR_W + 1)'(len_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_PREP;
            end

            S_PREP:
            begin
                if (action_reg == ACT_START)
                begin
                    // restart: full first chunk into buffer 0
                    row_sel          = layer_row(3'd0);
                    entry_next       = '0;
                    active_next      = 1'b0;
                    frames_left_next = row_sel.all_frames - FRAMES_W'(row_sel.load_frames);
                    chunk_next       = START_BYTES;
                    addr_next        = cfg.region_base + ADDR_W'(START_BYTES);
                    res_next         = '{1'b0, '0, 1'b1, 1'b0, cfg.region_base, START_BYTES};
                    state_next       = S_DONE;
                end
                else if (cfg.suspend_count != '0)
                begin
                    // drop the row
                    state_next = S_IDLE;
                end
                else
                begin
                    if (row_index_reg == '0)
                        chunk_next = chunk_of(row_sel);
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    if (mod_rem == '0)
                        state_next = S_LOAD1;
                    else
                    begin
                        res_next   = '{active_reg, OFFS_W'(mod_rem), 1'b0, 1'b0, '0, '0};
                        state_next = S_DONE;
                    end
                end
            end

            S_LOAD1:
            begin
                // flip buffers and pick the frames of the next load
                active_next = ~active_reg;
                if (frames_left_reg == '0)
                begin
                    if (entry_inc >= (ENTRY_W + 1)'(TABLE_ENTRIES))
                        entry_next = '0;
                    else
                        entry_next = entry_inc[ENTRY_W-1:0];
                    row_sel          = layer_row(entry_next);
                    frames_next      = row_sel.load_frames;
                    frames_left_next = row_sel.all_frames - FRAMES_W'(row_sel.load_frames);
                end
                else
                begin
                    if (frames_left_reg >= FRAMES_W'(row_sel.load_frames))
                        frames_next = row_sel.load_frames;
                    else
                        frames_next = LOADF_W'(frames_left_reg);
                    frames_left_next = frames_left_reg - FRAMES_W'(frames_next);
                end
                flen_next  = row_sel.frame_bytes;
                state_next = S_LOAD2;
            end

            S_LOAD2:
            begin
                len_next   = bound_bytes(16'(frames_reg) * 16'(flen_reg));
                end_next   = (LEN_W + 1)'(cfg.region_base) + (LEN_W + 1)'(cfg.region_length);
                state_next = S_LOAD3;
            end

            S_LOAD3:
            begin
                // advance the address, wrap at the region end
                if ((LEN_W + 1)'(adv) >= end_reg)
                    addr_next = cfg.region_base;
                else
                    addr_next = adv[ADDR_W-1:0];
                res_next   = '{active_reg, '0, 1'b1, ~active_reg, addr_reg, len_reg};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_reg       <= '0;
            frames_left_reg <= '0;
            active_reg      <= 1'b0;
            addr_reg        <= '0;
            chunk_reg       <= START_BYTES;
        end
        else
        begin
            state_reg       <= state_next;
            entry_reg       <= entry_next;
            frames_left_reg <= frames_left_next;
            active_reg      <= active_next;
            addr_reg        <= addr_next;
            chunk_reg       <= chunk_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg     <= action;
            row_index_reg  <= row_index;
            row_length_reg <= row_length;
        end
        frames_reg <= frames_next;
        flen_reg   <= flen_next;
        len_reg    <= len_next;
        end_reg    <= end_next;
        res_reg    <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ----- hw/rtl/wps_checker.sv -----
// Port-level checks of the weight prefetch scheduler, bound to its top level.
// Depends only on the port names of weight_prefetch_scheduler_unit.
module wps_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [55:0]                     m_tdata,
    input  logic [0:0]                      m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One request at a time: no acceptance right after an acceptance
    a_serial: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // Load fields are zero without a load
    a_noload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[52:14] == 39'd0)
        else $error("load fields set without load_issue");

    // A load never fills buffer 1 while buffer 1 is being read
    a_other: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !(m_tdata[14] && m_tdata[0]))
        else $error("load targets the read buffer");

    // A load only starts at a chunk boundary
    a_offs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13:1] != 13'd0 |-> !m_tuser[0])
        else $error("load issued at nonzero offset");

endmodule

bind weight_prefetch_scheduler_unit wps_checker u_wps_checker (.*);
